[design/rpn_pkg.sv]
package rpn_pkg;

    // Action codes carried in one input beat
    localparam logic [3:0] ACT_PUSH = 4'd0;
    localparam logic [3:0] ACT_ADD  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_SUB  = 4'd3;
    localparam logic [3:0] ACT_DIV  = 4'd4;
    localparam logic [3:0] ACT_MOD  = 4'd5;
    localparam logic [3:0] ACT_POW  = 4'd6;
    localparam logic [3:0] ACT_XOR  = 4'd7;
    localparam logic [3:0] ACT_OR   = 4'd8;
    localparam logic [3:0] ACT_AND  = 4'd9;
    localparam logic [3:0] ACT_NOT  = 4'd10;
    localparam logic [3:0] ACT_DEC  = 4'd11;
    localparam logic [3:0] ACT_INC  = 4'd12;

    // Status reported with each result beat
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_POW_ISSUE,
        S_POW_WAIT,
        S_WB
    } t_state;

    // Multiplier bits consumed per cycle
    localparam int MUL_CHUNK = 16;

    // Start/done pair of an iterative arithmetic unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

[design/rpn_mul.sv]
module rpn_mul
    import rpn_pkg::*;
#(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_unit_req     i_req,
    input  logic [W-1:0]  i_a,
    input  logic [W-1:0]  i_b,
    output t_unit_rsp     o_rsp,
    output logic [W-1:0]  o_p
);

    localparam int CH    = (W < MUL_CHUNK) ? W : MUL_CHUNK;
    localparam int NSTEP = (W + CH - 1) / CH;
    localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_p;
    logic [W-1:0]  b_lo;
    logic [W-1:0]  part;

    // one W x CH partial product per cycle, low W bits kept
    assign b_lo = W'(r_b[CH-1:0]);
    assign part = r_a * b_lo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: multiplicand moves up, multiplier moves down by one chunk
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_a <= r_a << CH;
            r_b <= r_b >> CH;
            r_p <= r_p + part;
        end
    end

    assign o_rsp.done = r_done;
    assign o_p        = r_p;

endmodule

[design/rpn_div.sv]
module rpn_div
    import rpn_pkg::*;
#(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_unit_req     i_req,
    input  logic [W-1:0]  i_dividend,
    input  logic [W-1:0]  i_divisor,
    output t_unit_rsp     o_rsp,
    output logic [W-1:0]  o_quo,
    output logic [W-1:0]  o_rem
);

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;
    logic          r_qneg;
    logic          r_rneg;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    // restoring step: one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath on magnitudes, signs applied at the output
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            r_dvs  <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            r_rem  <= '0;
            r_qneg <= i_dividend[W-1] ^ i_divisor[W-1];
            r_rneg <= i_dividend[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    // truncating quotient, remainder takes the dividend's sign
    assign o_quo      = r_qneg ? (W'(0) - r_quo) : r_quo;
    assign o_rem      = r_rneg ? (W'(0) - r_rem) : r_rem;
    assign o_rsp.done = r_done;

endmodule

[design/rpn_stack_calculator.sv]
// Reverse-Polish integer calculator. Each input beat pushes a value or applies
// one operation to the operand stack, which lives in a synchronous memory of
// STACK_DEPTH entries; every input beat yields exactly one result beat with the
// new top of stack (zero when empty), the entry count and a status. Faults
// (underflow, overflow, divide by zero) leave the stack untouched. Items are
// handled one at a time and the input stalls while one is in work, but a new
// item is taken while the previous result still waits in the output register.
// Each item passes through execute and writeback, and the sequencer returns to
// idle before the next accept; mul also runs the iterative multiplier over
// NSTEP = ceil(DATA_WIDTH/16) chunks, div and mod the bit-serial divider, and
// pow one square-and-multiply round for each exponent bit up to its highest
// set bit, and every round runs the two multipliers once. Writeback waits
// while the output register still holds a result that the consumer stalls.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_operand_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_top_value,
    output logic [4:0]         o_stack_count,
    output logic [1:0]         o_status
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);

    t_state        r_state, n_state;
    logic [SW-1:0] r_sp;
    logic [3:0]    r_act;
    logic [31:0]   r_val;

    // pending writeback
    logic [W-1:0]  r_res,   n_res;
    logic          r_wen,   n_wen;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [SW-1:0] r_nsp,   n_nsp;
    t_status       r_st,    n_st;

    // power loop
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_sq,  n_sq;
    logic [W-1:0]  r_exp, n_exp;

    // output register
    logic          r_o_valid;
    logic [31:0]   r_o_top;
    logic [4:0]    r_o_count;
    logic [1:0]    r_o_status;

    // stack memory and its registered read ports
    logic [W-1:0]  mem [STACK_DEPTH];
    logic [W-1:0]  r_rd_top;
    logic [W-1:0]  r_rd_nxt;
    logic [SW-1:0] sp_m1;
    logic [SW-1:0] sp_m2;

    logic          in_acc;
    logic          out_acc;
    logic          commit;
    logic [W-1:0]  x;
    logic [W-1:0]  y;
    logic [W-1:0]  top_next;

    t_unit_req     mul0_req, mul1_req, div_req;
    t_unit_rsp     mul0_rsp, mul1_rsp, div_rsp;
    logic [W-1:0]  mul0_a, mul0_b, mul0_p, mul1_p;
    logic [W-1:0]  div_quo, div_rem;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_o_valid && !i_out_stall;
    assign commit  = (r_state == S_WB) && (!r_o_valid || !i_out_stall);
    assign sp_m1   = r_sp - SW'(1);
    assign sp_m2   = r_sp - SW'(2);
    assign x       = r_rd_top;
    assign y       = r_rd_nxt;

    // reads track the pointer every cycle; the write lands at commit
    always_ff @(posedge i_clk) begin
        if (commit && r_wen) begin
            mem[r_waddr] <= r_res;
        end
        r_rd_top <= mem[sp_m1[AW-1:0]];
        r_rd_nxt <= mem[sp_m2[AW-1:0]];
    end

    // arithmetic units: u_mul0 shared by mul and pow, u_mul1 for pow only, u_div for div and mod
    assign mul0_a = (r_state == S_EXEC) ? y : r_acc;
    assign mul0_b = (r_state == S_EXEC) ? x : r_sq;

    rpn_mul #(.W(W)) u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul0_req),
        .i_a     (mul0_a),
        .i_b     (mul0_b),
        .o_rsp   (mul0_rsp),
        .o_p     (mul0_p)
    );

    rpn_mul #(.W(W)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul1_req),
        .i_a     (r_sq),
        .i_b     (r_sq),
        .o_rsp   (mul1_rsp),
        .o_p     (mul1_p)
    );

    rpn_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (y),
        .i_divisor  (x),
        .o_rsp      (div_rsp),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // sequencer: decode, run the long ops, hold the writeback
    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        n_wen          = r_wen;
        n_waddr        = r_waddr;
        n_nsp          = r_nsp;
        n_st           = r_st;
        n_acc          = r_acc;
        n_sq           = r_sq;
        n_exp          = r_exp;
        mul0_req.start = 1'b0;
        mul1_req.start = 1'b0;
        div_req.start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_WB;
                n_wen   = 1'b0;
                n_nsp   = r_sp;
                n_st    = ST_OK;
                n_res   = '0;
                n_waddr = sp_m1[AW-1:0];
                case (r_act)
                    ACT_PUSH: begin
                        if (r_sp >= SW'(STACK_DEPTH)) begin
                            n_st = ST_OVER;
                        end else begin
                            n_wen   = 1'b1;
                            n_waddr = r_sp[AW-1:0];
                            n_nsp   = r_sp + SW'(1);
                            n_res   = W'($signed(r_val));
                        end
                    end
                    ACT_ADD, ACT_MUL, ACT_SUB, ACT_DIV, ACT_MOD,
                    ACT_POW, ACT_XOR, ACT_OR, ACT_AND: begin
                        if (r_sp < SW'(2)) begin
                            n_st = ST_UNDER;
                        end else if ((r_act == ACT_DIV || r_act == ACT_MOD) && x == '0) begin
                            n_st = ST_DIVZERO;
                        end else begin
                            n_wen   = 1'b1;
                            n_waddr = sp_m2[AW-1:0];
                            n_nsp   = sp_m1;
                            case (r_act)
                                ACT_ADD: n_res = y + x;
                                ACT_SUB: n_res = y - x;
                                ACT_XOR: n_res = y ^ x;
                                ACT_OR:  n_res = y | x;
                                ACT_AND: n_res = y & x;
                                ACT_MUL: begin
                                    mul0_req.start = 1'b1;
                                    n_state        = S_MUL;
                                end
                                ACT_DIV, ACT_MOD: begin
                                    div_req.start = 1'b1;
                                    n_state       = S_DIV;
                                end
                                default: begin
                                    // power: zero exponent gives one, negative gives base
                                    if (x == '0) begin
                                        n_res = W'(1);
                                    end else if (x[W-1]) begin
                                        n_res = y;
                                    end else begin
                                        n_acc   = W'(1);
                                        n_sq    = y;
                                        n_exp   = x;
                                        n_state = S_POW_ISSUE;
                                    end
                                end
                            endcase
                        end
                    end
                    ACT_NOT, ACT_DEC, ACT_INC: begin
                        if (r_sp == '0) begin
                            n_st = ST_UNDER;
                        end else begin
                            n_wen = 1'b1;
                            case (r_act)
                                ACT_NOT: n_res = ~x;
                                ACT_DEC: n_res = x - W'(1);
                                default: n_res = x + W'(1);
                            endcase
                        end
                    end
                    default: begin
                        // unused codes: nothing changes
                        n_st = ST_OK;
                    end
                endcase
            end
            S_MUL: begin
                if (mul0_rsp.done) begin
                    n_res   = mul0_p;
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = (r_act == ACT_DIV) ? div_quo : div_rem;
                    n_state = S_WB;
                end
            end
            S_POW_ISSUE: begin
                if (r_exp == '0) begin
                    n_res   = r_acc;
                    n_state = S_WB;
                end else begin
                    mul0_req.start = 1'b1;
                    mul1_req.start = 1'b1;
                    n_state        = S_POW_WAIT;
                end
            end
            S_POW_WAIT: begin
                // both multipliers start together and finish together
                if (mul0_rsp.done && mul1_rsp.done) begin
                    if (r_exp[0]) begin
                        n_acc = mul0_p;
                    end
                    n_sq    = mul1_p;
                    n_exp   = r_exp >> 1;
                    n_state = S_POW_ISSUE;
                end
            end
            S_WB: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_sp      <= r_nsp;
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act <= i_action;
            r_val <= i_operand_value;
        end
        r_res   <= n_res;
        r_wen   <= n_wen;
        r_waddr <= n_waddr;
        r_nsp   <= n_nsp;
        r_st    <= n_st;
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_exp   <= n_exp;
        if (commit) begin
            r_o_top    <= 32'(top_next);
            r_o_count  <= 5'(r_nsp);
            r_o_status <= r_st;
        end
    end

    // top after the step: written value, else the unchanged top (zero when empty)
    assign top_next = r_wen ? r_res : ((r_sp == '0) ? '0 : r_rd_top);

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_top_value   = r_o_top;
    assign o_stack_count = r_o_count;
    assign o_status      = r_o_status;

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_EXEC)
        else $error("accepted beat did not enter execute");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_wen) |-> r_nsp != '0)
        else $error("write with empty resulting stack");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid && o_stack_count == $past(5'(r_nsp)))
        else $error("result beat not loaded at commit");

endmodule
